>>> rtl/lru_dir_pkg.sv
// Shared types, constants and codes for the LRU cache directory.
package lru_dir_pkg;

  localparam int DEFAULT_SLOTS = 64;
  localparam int TAG_W = 32;
  localparam int SLOT_W = 6;

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_INVAL = 1'b1;

  localparam logic [1:0] ST_HIT = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_INVAL = 2'd3;

  typedef struct packed {
    logic lookup;
    logic update;
    logic inval;
  } dir_cmd_t;

  typedef struct packed {
    logic hit;
    logic in_range;
    logic op_inval;
  } dir_stat_t;

endpackage

>>> rtl/lru_dir_ctrl.sv
// Controller state machine of the LRU cache directory.
module lru_dir_ctrl
  import lru_dir_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dir_stat_t stat,
  output dir_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_UPD = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = S_LOOK;
      end
      S_LOOK: begin
        cmd.lookup = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        if (stat.op_inval) cmd.inval = 1'b1;
        else if (stat.hit || stat.in_range) cmd.update = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

>>> rtl/lru_dir_dp.sv
// Datapath of the LRU cache directory: tags, valid bits, ranks and result.
module lru_dir_dp
  import lru_dir_pkg::*;
#(
  parameter int SLOTS = DEFAULT_SLOTS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [TAG_W-1:0]  cfg_data,
  input  logic              accept,
  input  logic              operation,
  input  logic [TAG_W-1:0]  block_index,
  input  logic [SLOT_W-1:0] slot,
  input  dir_cmd_t          cmd,
  output dir_stat_t         stat,
  output logic [1:0]        status,
  output logic [SLOT_W-1:0] slot_used,
  output logic              evicted_valid,
  output logic [TAG_W-1:0]  evicted_block
);

  localparam int IW = $clog2(SLOTS);

  logic [TAG_W-1:0] block_count;
  logic [TAG_W-1:0] tag [SLOTS];
  logic [SLOTS-1:0] valid;
  logic [IW-1:0] rank [SLOTS];

  logic op_q;
  logic [TAG_W-1:0] idx_q;
  logic [SLOT_W-1:0] sl_q;

  logic hit_q, inr_q;
  logic [IW-1:0] sel_q;
  logic [IW-1:0] sel_rank_q;

  logic [SLOTS-1:0] match, lru;
  logic hit_c;
  logic [IW-1:0] hs_c, ls_c, sel_c;

  always_comb begin
    hs_c = '0;
    ls_c = '0;
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = valid[i] && (tag[i] == idx_q);
      lru[i] = (rank[i] == '0);
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match[i]) hs_c = IW'(i);
      if (lru[i]) ls_c = IW'(i);
    end
    hit_c = |match;
    sel_c = hit_c ? hs_c : ls_c;
  end

  assign stat.hit = hit_q;
  assign stat.in_range = inr_q;
  assign stat.op_inval = op_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= '0;
      valid <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        tag[i] <= '0;
        rank[i] <= IW'(i);
      end
    end else begin
      if (cfg_we) block_count <= cfg_data;
      if (cmd.update) begin
        for (int i = 0; i < SLOTS; i++)
          if (rank[i] > sel_rank_q) rank[i] <= rank[i] - 1'b1;
        rank[sel_q] <= IW'(SLOTS - 1);
        tag[sel_q] <= idx_q;
        valid[sel_q] <= 1'b1;
      end
      if (cmd.inval && ({3'b0, sl_q} < (SLOT_W + 3)'(SLOTS))) begin
        tag[IW'(sl_q)] <= '0;
        valid[IW'(sl_q)] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= operation;
      idx_q <= block_index;
      sl_q <= slot;
    end
    if (cmd.lookup) begin
      hit_q <= hit_c;
      inr_q <= idx_q < block_count;
      sel_q <= sel_c;
      sel_rank_q <= rank[sel_c];
      status <= op_q ? ST_INVAL : hit_c ? ST_HIT :
                (idx_q < block_count) ? ST_MISS : ST_RANGE;
      evicted_valid <= 1'b0;
      evicted_block <= '0;
      slot_used <= '0;
      if (op_q == OP_INVAL) begin
        slot_used <= sl_q;
      end else if (hit_c) begin
        slot_used <= SLOT_W'(hs_c);
      end else if (idx_q < block_count) begin
        slot_used <= SLOT_W'(ls_c);
        evicted_valid <= valid[ls_c];
        evicted_block <= valid[ls_c] ? tag[ls_c] : '0;
      end
    end
  end

endmodule

>>> rtl/lru_block_cache_directory_top.sv
// Top level of the LRU block cache directory.
// Each beat passes through the accepting cycle, a parallel tag compare and least-recent search
// over all slots, a rank and tag update on a hit or in-range miss (or the slot invalidate),
// then the output beat. One item is in flight at a time; the next is accepted once the result
// is taken. Reset initializes all slots directly, with no clearing pass.
module lru_block_cache_directory_top
  import lru_dir_pkg::*;
#(
  parameter int SLOTS = DEFAULT_SLOTS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [TAG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  input  logic [TAG_W-1:0]  block_index,
  input  logic [SLOT_W-1:0] slot,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [SLOT_W-1:0] slot_used,
  output logic              evicted_valid,
  output logic [TAG_W-1:0]  evicted_block
);

  dir_cmd_t cmd;
  dir_stat_t stat;

  lru_dir_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  lru_dir_dp #(.SLOTS(SLOTS)) u_dp (
    .clk, .rst, .cfg_we, .cfg_data,
    .accept(in_valid && in_ready),
    .operation, .block_index, .slot, .cmd, .stat,
    .status, .slot_used, .evicted_valid, .evicted_block
  );

  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output sides open together");
  a_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted_valid |-> status == ST_MISS)
    else $error("eviction reported without a miss");
  a_cmd: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("conflicting datapath commands");

endmodule

>>> verif/lru_dir_checker.sv
// Checker that predicts LRU directory results and compares them with the output beats.
`timescale 1ns / 100ps
module lru_dir_checker
  import lru_dir_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [TAG_W-1:0]  cfg_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              operation,
  input  logic [TAG_W-1:0]  block_index,
  input  logic [SLOT_W-1:0] slot,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [1:0]        status,
  input  logic [SLOT_W-1:0] slot_used,
  input  logic              evicted_valid,
  input  logic [TAG_W-1:0]  evicted_block,
  output int                fail_count,
  output int                pending_count,
  output int                hit_count,
  output int                miss_count,
  output int                evict_count,
  output int                refuse_count,
  output int                inval_count
);
  localparam int NSLOT = DEFAULT_SLOTS;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot_used;
    logic              evicted_valid;
    logic [TAG_W-1:0]  evicted_block;
  } dir_result_t;

  logic [TAG_W-1:0]  tag_model [NSLOT];
  logic              valid_model [NSLOT];
  logic [SLOT_W-1:0] rank_model [NSLOT];
  logic [TAG_W-1:0]  count_model;
  dir_result_t       expected_results [$];

  task automatic promote_slot(input int s);
    logic [SLOT_W-1:0] r;
    r = rank_model[s];
    for (int i = 0; i < NSLOT; i++) begin
      if (rank_model[i] > r) rank_model[i] = rank_model[i] - 1'b1;
    end
    rank_model[s] = SLOT_W'(NSLOT - 1);
  endtask

  function automatic int oldest_slot();
    for (int i = 0; i < NSLOT; i++) begin
      if (rank_model[i] == 0) return i;
    end
    return 0;
  endfunction

  task automatic predict_lookup(input logic op, input logic [TAG_W-1:0] idx,
                                input logic [SLOT_W-1:0] sl);
    dir_result_t res;
    int hs;
    int v;
    res = '0;
    hs = -1;
    if (op == OP_INVAL) begin
      tag_model[sl] = '0;
      valid_model[sl] = 1'b0;
      res.status = ST_INVAL;
      res.slot_used = sl;
      inval_count++;
    end else begin
      for (int i = 0; i < NSLOT; i++) begin
        if (hs < 0 && valid_model[i] && tag_model[i] == idx) hs = i;
      end
      if (hs >= 0) begin
        promote_slot(hs);
        res.status = ST_HIT;
        res.slot_used = SLOT_W'(hs);
        hit_count++;
      end else if (idx >= count_model) begin
        res.status = ST_RANGE;
        refuse_count++;
      end else begin
        v = oldest_slot();
        if (valid_model[v]) begin
          res.evicted_valid = 1'b1;
          res.evicted_block = tag_model[v];
          evict_count++;
        end
        tag_model[v] = idx;
        valid_model[v] = 1'b1;
        promote_slot(v);
        res.status = ST_MISS;
        res.slot_used = SLOT_W'(v);
        miss_count++;
      end
    end
    expected_results.push_back(res);
  endtask

  always @(posedge clk) begin
    dir_result_t want;
    dir_result_t got;
    if (rst) begin
      for (int i = 0; i < NSLOT; i++) begin
        tag_model[i] = '0;
        valid_model[i] = 1'b0;
        rank_model[i] = SLOT_W'(i);
      end
      count_model = '0;
      expected_results.delete();
      fail_count = 0;
      hit_count = 0;
      miss_count = 0;
      evict_count = 0;
      refuse_count = 0;
      inval_count = 0;
    end else begin
      if (cfg_we) count_model = cfg_data;
      if (out_valid && out_ready) begin
        got = '{status, slot_used, evicted_valid, evicted_block};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Unexpected result beat: %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("Result mismatch: expected %p, actual %p", want, got);
          end
        end
      end
      if (in_valid && in_ready) predict_lookup(operation, block_index, slot);
    end
    pending_count = expected_results.size();
  end
endmodule

>>> verif/lru_block_cache_directory_top_test.sv
// Testbench top: drives lookups and invalidates into the LRU directory and gives the verdict.
`timescale 1ns / 100ps
module lru_block_cache_directory_top_test;
  import lru_dir_pkg::*;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [TAG_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic              operation;
  logic [TAG_W-1:0]  block_index;
  logic [SLOT_W-1:0] slot;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        status;
  logic [SLOT_W-1:0] slot_used;
  logic              evicted_valid;
  logic [TAG_W-1:0]  evicted_block;
  int                fail_count;
  int                pending_count;
  int                hit_count;
  int                miss_count;
  int                evict_count;
  int                refuse_count;
  int                inval_count;
  bit                calm_phase;
  int                sent_count;

  lru_block_cache_directory_top u_top (.*);
  lru_dir_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= calm_phase || ($urandom_range(99) >= 12);
  end

  task automatic send_beat(input logic op, input logic [TAG_W-1:0] idx,
                           input logic [SLOT_W-1:0] sl);
    while (!calm_phase && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    block_index <= idx;
    slot <= sl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_block_count(input logic [TAG_W-1:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int n, input logic [TAG_W-1:0] limit);
    logic [TAG_W-1:0] idx;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: idx = $urandom();
        1: idx = limit + $urandom_range(3);
        2: idx = (limit == 0) ? 0 : limit - 1;
        default: idx = $urandom_range(95);
      endcase
      if ($urandom_range(9) == 0)
        send_beat(OP_INVAL, $urandom(), SLOT_W'($urandom_range(63)));
      else send_beat(OP_ACCESS, idx, SLOT_W'($urandom_range(63)));
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = OP_ACCESS;
    block_index = '0;
    slot = '0;
    calm_phase = 1'b0;
    sent_count = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_beat(OP_ACCESS, 32'd0, 6'd0);
    send_beat(OP_ACCESS, 32'hFFFF_FFFF, 6'd63);
    send_beat(OP_INVAL, 32'd0, 6'd63);
    set_block_count(32'hFFFF_FFFF);
    send_beat(OP_ACCESS, 32'hFFFF_FFFE, 6'd0);
    send_beat(OP_ACCESS, 32'hFFFF_FFFF, 6'd0);
    send_beat(OP_ACCESS, 32'd0, 6'd0);
    send_beat(OP_ACCESS, 32'hFFFF_FFFE, 6'd0);
    send_beat(OP_INVAL, 32'hFFFF_FFFF, 6'd0);
    send_beat(OP_INVAL, 32'd0, 6'd0);
    send_beat(OP_ACCESS, 32'h5555_5555, 6'h2A);
    send_beat(OP_ACCESS, 32'hAAAA_AAAA, 6'h15);
    set_block_count(32'd3);
    send_beat(OP_ACCESS, 32'hFFFF_FFFE, 6'd0);
    send_beat(OP_ACCESS, 32'd3, 6'd0);
    send_beat(OP_ACCESS, 32'd2, 6'd0);
    for (int i = 0; i < 66; i++) send_beat(OP_ACCESS, i % 3, 6'd0);

    set_block_count(32'd80);
    random_phase(120, 32'd80);
    drain_results();
    calm_phase = 1'b1;
    random_phase(100, 32'd80);
    calm_phase = 1'b0;
    set_block_count(32'd40);
    random_phase(100, 32'd40);
    set_block_count(32'd0);
    random_phase(30, 32'd0);
    set_block_count(32'd70);
    random_phase(80, 32'd70);

    drain_results();
    $display("Sent %0d beats: %0d hits, %0d misses (%0d evictions), %0d refused, %0d invalidates.",
             sent_count, hit_count, miss_count, evict_count, refuse_count, inval_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
